// ----- hw/rtl/shift_light_bar_with_boot_sweep_top_defines.svh -----
// Assertion macros used by the checker file of the shift-light bar.
`ifndef SHIFT_LIGHT_BAR_WITH_BOOT_SWEEP_TOP_DEFINES_SVH
`define SHIFT_LIGHT_BAR_WITH_BOOT_SWEEP_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/slb_pkg.sv -----
package slb_pkg;

  localparam int MASK_W    = 10;
  localparam int RPM_W     = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int SEGMENTS_DEF = 10;

  localparam logic [CFG_W-1:0] FIRST_RPM_RST = 16'd3500;
  localparam logic [CFG_W-1:0] LAST_RPM_RST  = 16'd7200;
  localparam logic [CFG_W-1:0] SWEEP_MS_RST  = 16'd1500;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RPM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_RPM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MS  = 2'd2;

  typedef struct packed {
    logic [MASK_W-1:0] red;
    logic [MASK_W-1:0] amber;
    logic [MASK_W-1:0] green;
  } masks_t;

  typedef struct packed {
    logic load;
    logic calc_rem;
    logic expire;
    logic calc_elapsed;
    logic phase;
    logic rpm_eval;
    logic div_step;
    logic sweep_fill;
    logic rpm_lit;
    logic apply;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic swp_run;
    logic expired;
    logic lt_half;
    logic fresh;
    logic rpm_div;
    logic div_done;
  } dp_status_t;

  function automatic masks_t bar_for_count(input int lit, input int segs);
    masks_t m;
    int     i;
    m = '0;
    for (i = 0; i < MASK_W; i++) begin
      if (i < segs && i < lit) begin
        if (i >= segs - 3) begin
          m.red[i] = 1'b1;
        end else if (i >= segs - 7) begin
          m.amber[i] = 1'b1;
        end else begin
          m.green[i] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  function automatic masks_t all_red(input int segs);
    masks_t m;
    int     i;
    m = '0;
    for (i = 0; i < MASK_W; i++) begin
      if (i < segs) begin
        m.red[i] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// ----- hw/rtl/slb_in_if.sv -----
interface slb_in_if;
  logic                          valid;
  logic                          ready;
  logic [slb_pkg::TIME_W-1:0]    now_ms;
  logic [slb_pkg::RPM_W-1:0]     rpm;
  logic                          rpm_fresh;

  modport source(output valid, now_ms, rpm, rpm_fresh, input ready);
  modport sink(input valid, now_ms, rpm, rpm_fresh, output ready);
endinterface

// ----- hw/rtl/slb_out_if.sv -----
interface slb_out_if;
  logic                          valid;
  logic                          ready;
  logic [slb_pkg::MASK_W-1:0]    green_mask;
  logic [slb_pkg::MASK_W-1:0]    amber_mask;
  logic [slb_pkg::MASK_W-1:0]    red_mask;
  logic                          sweep_active;
  logic                          repainted;

  modport source(output valid, green_mask, amber_mask, red_mask, sweep_active, repainted,
                 input ready);
  modport sink(input valid, green_mask, amber_mask, red_mask, sweep_active, repainted,
               output ready);
endinterface

// ----- hw/rtl/slb_cfg_if.sv -----
interface slb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [slb_pkg::CFG_IDX_W-1:0]   index;
  logic [slb_pkg::CFG_W-1:0]       data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/shift_light_bar_with_boot_sweep_top.sv -----
// RPM shift-light bar with a power-up sweep.
// in_ch carries one transaction per time tick or rpm reading: now_ms, rpm and
// rpm_fresh. Every input transaction yields exactly one out_ch transaction with
// the green, amber and red segment masks, sweep_active and repainted.
// cfg_ch writes shift_first_rpm (index 0), shift_last_rpm (1) and sweep_ms (2);
// it is always ready and other indexes are dropped. Write it only while idle.
// The first input transaction arms the sweep; the bar fills, turns red, goes
// dark, and is repainted on the first fresh rpm after the sweep ends.
// The lit count comes from a repeated-subtraction divider that counts one lit
// segment per cycle, so an item takes longer the more segments it lights.
// One item is worked at a time; in_ch.ready is high only while the controller
// is idle. A finished result sits in the output register while the next item
// is taken and worked; if out_ch stalls, the next result waits in the final
// state until the register frees.
// Reset (rst_n low, synchronous) restores the register defaults, disarms the
// sweep, clears the shown bar and empties the output register.
module shift_light_bar_with_boot_sweep_top #(
  parameter int SEGMENTS = slb_pkg::SEGMENTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  slb_in_if.sink     in_ch,
  slb_out_if.source  out_ch,
  slb_cfg_if.sink    cfg_ch
);

  slb_pkg::ctrl_cmd_t  cmd;
  slb_pkg::dp_status_t status;
  slb_pkg::masks_t     masks;

  assign cfg_ch.ready = 1'b1;

  slb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  slb_dp #(
    .SEGMENTS (SEGMENTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .in_now_ms        (in_ch.now_ms),
    .in_rpm           (in_ch.rpm),
    .in_rpm_fresh     (in_ch.rpm_fresh),
    .cmd              (cmd),
    .status           (status),
    .out_masks        (masks),
    .out_sweep_active (out_ch.sweep_active),
    .out_repainted    (out_ch.repainted)
  );

  assign out_ch.green_mask = masks.green;
  assign out_ch.amber_mask = masks.amber;
  assign out_ch.red_mask   = masks.red;

endmodule

// ----- hw/rtl/slb_dp.sv -----
module slb_dp #(
  parameter int SEGMENTS = slb_pkg::SEGMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [slb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slb_pkg::CFG_W-1:0]       cfg_data,
  input  logic [slb_pkg::TIME_W-1:0]      in_now_ms,
  input  logic [slb_pkg::RPM_W-1:0]       in_rpm,
  input  logic                            in_rpm_fresh,
  input  slb_pkg::ctrl_cmd_t              cmd,
  output slb_pkg::dp_status_t             status,
  output slb_pkg::masks_t                 out_masks,
  output logic                            out_sweep_active,
  output logic                            out_repainted
);

  localparam int CW   = $clog2(SEGMENTS + 1);
  localparam int DIVW = slb_pkg::RPM_W + CW;
  localparam int TW   = slb_pkg::TIME_W;
  localparam int RW   = slb_pkg::RPM_W;

  localparam logic [1:0] SWP_IDLE = 2'd0;
  localparam logic [1:0] SWP_RUN  = 2'd1;
  localparam logic [1:0] SWP_DONE = 2'd2;

  localparam logic [CW-1:0] SEG_C = CW'(SEGMENTS);

  logic [slb_pkg::CFG_W-1:0] first_rpm_r, last_rpm_r, sweep_ms_r;

  logic [TW-1:0]    now_r;
  logic [RW-1:0]    rpm_r;
  logic             fresh_r;
  logic [TW-1:0]    end_r;
  logic [1:0]       swp_r;
  logic [TW-1:0]    rem_r;
  logic [TW-1:0]    elapsed_r;
  logic             force_r;
  logic [CW-1:0]    shown_r;
  logic [CW-1:0]    lit_r;
  slb_pkg::masks_t  masks_r;
  slb_pkg::masks_t  last_r;
  logic             sweeping_r;

  logic [DIVW-1:0]  div_rem_r;
  logic [RW-1:0]    div_dvs_r;
  logic [CW-1:0]    div_q_r;

  slb_pkg::masks_t  out_masks_r;
  logic             out_sweep_r;
  logic             out_rep_r;

  logic [RW+1:0]    sweep3;
  logic [RW-1:0]    three_q;
  logic             lt_3q;
  logic [RW-1:0]    rpm_diff;
  logic [DIVW-1:0]  div_dvs_ext;
  logic             div_ge;
  logic [CW-1:0]    fill_lit;

  always_comb begin
    sweep3      = {2'b00, sweep_ms_r} + {1'b0, sweep_ms_r, 1'b0};
    three_q     = sweep3[RW+1:2];
    lt_3q       = elapsed_r < TW'(three_q);
    rpm_diff    = rpm_r - first_rpm_r;
    div_dvs_ext = DIVW'(div_dvs_r);
    div_ge      = div_rem_r >= div_dvs_ext;
    fill_lit    = (div_q_r == SEG_C) ? SEG_C : div_q_r + CW'(1);
  end

  assign status.swp_run  = swp_r == SWP_RUN;
  assign status.expired  = (rem_r == '0) || rem_r[TW-1];
  assign status.lt_half  = elapsed_r < TW'(sweep_ms_r[RW-1:1]);
  assign status.fresh    = fresh_r;
  assign status.rpm_div  = (rpm_r > first_rpm_r) && (last_rpm_r > first_rpm_r);
  assign status.div_done = !div_ge || (div_q_r == SEG_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_rpm_r <= slb_pkg::FIRST_RPM_RST;
      last_rpm_r  <= slb_pkg::LAST_RPM_RST;
      sweep_ms_r  <= slb_pkg::SWEEP_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        slb_pkg::CFG_FIRST_RPM: first_rpm_r <= cfg_data;
        slb_pkg::CFG_LAST_RPM:  last_rpm_r  <= cfg_data;
        slb_pkg::CFG_SWEEP_MS:  sweep_ms_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_r   <= SWP_IDLE;
      end_r   <= '0;
      force_r <= 1'b0;
      shown_r <= '0;
      last_r  <= '0;
    end else begin
      if (cmd.load && swp_r == SWP_IDLE) begin
        end_r <= in_now_ms + TW'(sweep_ms_r);
        swp_r <= SWP_RUN;
      end
      if (cmd.expire) begin
        swp_r   <= SWP_DONE;
        force_r <= 1'b1;
      end
      if (cmd.apply && (force_r || lit_r != shown_r)) begin
        shown_r <= lit_r;
        force_r <= 1'b0;
      end
      if (cmd.emit) begin
        last_r <= masks_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r      <= in_now_ms;
      rpm_r      <= in_rpm;
      fresh_r    <= in_rpm_fresh;
      masks_r    <= last_r;
      sweeping_r <= 1'b0;
    end
    if (cmd.calc_rem) begin
      rem_r <= end_r - now_r;
    end
    if (cmd.expire) begin
      masks_r <= '0;
    end
    if (cmd.calc_elapsed) begin
      elapsed_r  <= TW'(sweep_ms_r) - rem_r;
      sweeping_r <= 1'b1;
    end
    if (cmd.phase) begin
      if (status.lt_half) begin
        div_rem_r <= DIVW'(elapsed_r[RW-2:0]) * DIVW'(SEGMENTS);
        div_dvs_r <= {1'b0, sweep_ms_r[RW-1:1]};
        div_q_r   <= '0;
      end else if (lt_3q) begin
        masks_r <= slb_pkg::all_red(SEGMENTS);
      end else begin
        masks_r <= '0;
      end
    end
    if (cmd.rpm_eval) begin
      if (status.rpm_div) begin
        div_rem_r <= DIVW'(rpm_diff) * DIVW'(SEGMENTS);
        div_dvs_r <= last_rpm_r - first_rpm_r;
        div_q_r   <= '0;
      end else begin
        lit_r <= (rpm_r > first_rpm_r) ? SEG_C : '0;
      end
    end
    if (cmd.div_step && div_ge && div_q_r != SEG_C) begin
      div_rem_r <= div_rem_r - div_dvs_ext;
      div_q_r   <= div_q_r + CW'(1);
    end
    if (cmd.sweep_fill) begin
      masks_r <= slb_pkg::bar_for_count(int'(fill_lit), SEGMENTS);
    end
    if (cmd.rpm_lit) begin
      lit_r <= div_q_r;
    end
    if (cmd.apply && (force_r || lit_r != shown_r)) begin
      masks_r <= slb_pkg::bar_for_count(int'(lit_r), SEGMENTS);
    end
    if (cmd.emit) begin
      out_masks_r <= masks_r;
      out_sweep_r <= sweeping_r;
      out_rep_r   <= masks_r != last_r;
    end
  end

  assign out_masks        = out_masks_r;
  assign out_sweep_active = out_sweep_r;
  assign out_repainted    = out_rep_r;

endmodule

// ----- hw/rtl/slb_ctrl.sv -----
module slb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  slb_pkg::dp_status_t  status,
  output slb_pkg::ctrl_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_PHASE = 3'd3;
  localparam logic [2:0] S_RPM   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_APPLY = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       div_sweep_r, div_sweep_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    div_sweep_nxt = div_sweep_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (status.swp_run) begin
          cmd.calc_rem = 1'b1;
          state_nxt    = S_CHK;
        end else begin
          state_nxt = S_RPM;
        end
      end
      S_CHK: begin
        if (status.expired) begin
          cmd.expire = 1'b1;
          state_nxt  = S_RPM;
        end else begin
          cmd.calc_elapsed = 1'b1;
          state_nxt        = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd.phase = 1'b1;
        if (status.lt_half) begin
          div_sweep_nxt = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_RPM: begin
        if (!status.fresh) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.rpm_eval = 1'b1;
          if (status.rpm_div) begin
            div_sweep_nxt = 1'b0;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_DIV: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else if (div_sweep_r) begin
          cmd.sweep_fill = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.rpm_lit = 1'b1;
          state_nxt   = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_sweep_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_sweep_r <= div_sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/slb_checker.sv -----
`include "shift_light_bar_with_boot_sweep_top_defines.svh"

module slb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [slb_pkg::MASK_W-1:0]    green_mask,
  input logic [slb_pkg::MASK_W-1:0]    amber_mask,
  input logic [slb_pkg::MASK_W-1:0]    red_mask,
  input logic                          sweep_active,
  input logic                          repainted
);

  logic [3*slb_pkg::MASK_W-1:0] prev_r;
  logic [1:0]                   pend_r, pend_nxt;
  logic                         in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (out_acc) begin
        prev_r <= {red_mask, amber_mask, green_mask};
      end
    end
  end

  `SLB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(green_mask) && $stable(amber_mask) && $stable(red_mask) && $stable(sweep_active) && $stable(repainted), "slb: stalled result changed")
  `SLB_ASSERT_NOW(a_repaint, out_valid, repainted == ({red_mask, amber_mask, green_mask} != prev_r), "slb: repainted flag wrong")
  `SLB_ASSERT_NOW(a_no_extra, out_valid, pend_r != 2'd0, "slb: result without input")
  `SLB_ASSERT_NOW(a_pend_bound, 1'b1, pend_r != 2'd3, "slb: too many items in flight")

endmodule

bind shift_light_bar_with_boot_sweep_top slb_checker u_slb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .green_mask   (out_ch.green_mask),
  .amber_mask   (out_ch.amber_mask),
  .red_mask     (out_ch.red_mask),
  .sweep_active (out_ch.sweep_active),
  .repainted    (out_ch.repainted)
);
